### design/fbfe_pkg.sv
// Package for the filter bank frame energy block.
// Holds payload structs, field codes, fixed-point constants and the sequencer state type.
// Used by fbfe_biquad and filter_bank_frame_energy_top.
`default_nettype none
package fbfe_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 32;
   localparam int STATE_BITS  = SAMPLE_BITS + 24;
   localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
   localparam int PROD_SHIFT  = 6;
   localparam int OUT_SHIFT   = 23;
   localparam int ENERGY_BITS = 63;
   localparam int FRAME_BITS  = 18;
   localparam int FRAME_MAX   = 131072;
   localparam int NUM_COEF    = 5;

   localparam logic [4:0] FILTER_A = 5'd25;
   localparam logic [4:0] FILTER_C = 5'd26;

   localparam logic [2:0] SEL_B0 = 3'd0;
   localparam logic [2:0] SEL_B1 = 3'd1;
   localparam logic [2:0] SEL_B2 = 3'd2;
   localparam logic [2:0] SEL_A1 = 3'd3;
   localparam logic [2:0] SEL_A2 = 3'd4;

   localparam logic [1:0] KIND_A    = 2'd0;
   localparam logic [1:0] KIND_C    = 2'd1;
   localparam logic [1:0] KIND_Z    = 2'd2;
   localparam logic [1:0] KIND_BAND = 2'd3;

   localparam logic [1:0] REG_BANDS    = 2'd0;
   localparam logic [1:0] REG_SECTIONS = 2'd1;
   localparam logic [1:0] REG_FRAME    = 2'd2;

   localparam logic       ACTION_SAMPLE = 1'b0;
   localparam logic       ACTION_COEF   = 1'b1;

   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef coef_type [NUM_COEF-1:0]       coef_row_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [STATE_BITS-1:0]  delay_type;

   typedef struct packed {
      logic                  action;
      logic signed [23:0]    sample;
      logic [4:0]            coef_filter;
      logic [1:0]            coef_section;
      logic [2:0]            coef_select;
      logic signed [31:0]    coef_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  band;
      logic [62:0] energy;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic mul_x;
      logic round;
      logic mul_y;
   } bq_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL1,
      ST_ROUND,
      ST_MUL2,
      ST_WRITE,
      ST_EREAD,
      ST_EACC,
      ST_EMIT_READ,
      ST_EMIT_LOAD
   } state_type;

endpackage
`default_nettype wire

### design/filter_bank_frame_energy_top.sv
// Top level of the filter bank frame energy block: sequencer, coefficient, delay and
// energy memories, configuration registers and output register.
// Depends on fbfe_pkg and fbfe_biquad.
//
// The req channel carries either a coefficient write or an audio sample. A coefficient
// write gives no result. A sample runs through the A and C weighting sections and every
// band section in use, one section at a time through a shared biquad datapath, with
// state read from and written back to on-chip memories. Each section steps through
// read, multiply, round, multiply and write states, and each energy update through a
// read and an accumulate state; the section datapath and the single read port of
// each memory set this serial order.
// When a frame completes, the block sends 3 + bands transfers on rsp (A, C, Z, then
// bands, last set on the final one); a stalled rsp holds the sequencer and no new req
// transfer is taken until the run is out.
// The csr channel is always ready and should be written only while the block is idle.
// Reset clears all delays, sums and the sample count and restores the configuration
// defaults; the delay and energy memories clear at once through valid bits.
// Coefficients must be written first.
`default_nettype none
module filter_bank_frame_energy_top #(
   parameter int BANDS    = 25,
   parameter int SECTIONS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fbfe_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fbfe_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [17:0]       csr_data
);
   import fbfe_pkg::*;

   localparam int NSLOT = 2 + BANDS * SECTIONS;
   localparam int SW    = $clog2(NSLOT);
   localparam int NSUM  = 3 + BANDS;
   localparam int EW    = $clog2(NSUM);
   localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int CW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam logic [ENERGY_BITS-1:0] E_MAX = '1;

   state_type state_ff, state_in;

   logic [4:0]            bands_ff;
   logic [2:0]            sects_ff;
   logic [FRAME_BITS-1:0] flen_ff;
   logic [5:0]            nb_eff;
   logic [3:0]            ns_eff;
   logic [FRAME_BITS-1:0] fl_eff;

   logic [SW-1:0]         slot_ff, slot_in;
   logic [BW-1:0]         band_ff, band_in;
   logic [CW-1:0]         sect_ff, sect_in;
   logic [EW-1:0]         eidx_ff, eidx_in;
   logic [FRAME_BITS-1:0] count_ff, count_in;
   sample_type            x_ff, x_in, xcur_ff, xcur_in, yacc_ff, yacc_in;
   logic [2*SAMPLE_BITS-1:0] sq_ff, sq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   coef_row_type          coef_mem [NSLOT];
   coef_row_type          coef_rd_ff;
   logic [2*STATE_BITS-1:0] delay_mem [NSLOT];
   logic [2*STATE_BITS-1:0] delay_rd_ff;
   logic [NSLOT-1:0]      dvalid_ff;
   logic                  dval_rd_ff;
   logic [ENERGY_BITS-1:0] eng_mem [NSUM];
   logic [ENERGY_BITS-1:0] eng_rd_ff;
   logic [NSUM-1:0]       evalid_ff;
   logic                  eval_rd_ff;

   logic                  req_fire, coef_we, load_ok, is_last, emit_done, delay_we, eng_we;
   logic [SW-1:0]         cw_slot;
   delay_type             z1, z2, n1, n2;
   sample_type            bq_y;
   bq_ctrl_type           bq_ctrl;
   logic [ENERGY_BITS-1:0] eng_cur, eng_wdata;
   logic [ENERGY_BITS:0]  eng_sum;

   always_comb begin
      if (bands_ff == 5'd0) begin
         nb_eff = 6'd1;
      end else if (6'(bands_ff) > 6'(BANDS)) begin
         nb_eff = 6'(BANDS);
      end else begin
         nb_eff = 6'(bands_ff);
      end
      if (sects_ff == 3'd0) begin
         ns_eff = 4'd1;
      end else if (4'(sects_ff) > 4'(SECTIONS)) begin
         ns_eff = 4'(SECTIONS);
      end else begin
         ns_eff = 4'(sects_ff);
      end
      if (flen_ff == '0) begin
         fl_eff = FRAME_BITS'(1);
      end else if (flen_ff > FRAME_BITS'(FRAME_MAX)) begin
         fl_eff = FRAME_BITS'(FRAME_MAX);
      end else begin
         fl_eff = flen_ff;
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign is_last   = (6'(eidx_ff) == 6'd2 + nb_eff);
   assign emit_done = (state_ff == ST_EMIT_LOAD) && load_ok && is_last;

   always_comb begin
      coef_we = 1'b0;
      cw_slot = '0;
      if (req_fire && req_data.action == ACTION_COEF && req_data.coef_select <= SEL_A2) begin
         if (req_data.coef_filter == FILTER_A) begin
            coef_we = 1'b1;
            cw_slot = SW'(0);
         end else if (req_data.coef_filter == FILTER_C) begin
            coef_we = 1'b1;
            cw_slot = SW'(1);
         end else if (int'(req_data.coef_filter) < BANDS &&
                      int'(req_data.coef_section) < SECTIONS) begin
            coef_we = 1'b1;
            cw_slot = SW'(2 + int'(req_data.coef_filter) * SECTIONS +
                          int'(req_data.coef_section));
         end
      end
   end

   assign z1 = dval_rd_ff ? delay_rd_ff[2*STATE_BITS-1:STATE_BITS] : '0;
   assign z2 = dval_rd_ff ? delay_rd_ff[STATE_BITS-1:0] : '0;

   assign bq_ctrl = '{mul_x: (state_ff == ST_MUL1),
                      round: (state_ff == ST_ROUND),
                      mul_y: (state_ff == ST_MUL2)};

   fbfe_biquad u_biquad (
      .clock (clock),
      .ctrl  (bq_ctrl),
      .x     (xcur_ff),
      .coef  (coef_rd_ff),
      .z1    (z1),
      .z2    (z2),
      .y     (bq_y),
      .n1    (n1),
      .n2    (n2)
   );

   assign delay_we  = (state_ff == ST_WRITE);
   assign eng_we    = (state_ff == ST_EACC);
   assign eng_cur   = eval_rd_ff ? eng_rd_ff : '0;
   assign eng_sum   = {1'b0, eng_cur} + (ENERGY_BITS + 1)'(sq_ff);
   assign eng_wdata = eng_sum[ENERGY_BITS] ? E_MAX : eng_sum[ENERGY_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.action == ACTION_SAMPLE) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_ROUND;
         ST_ROUND: state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (slot_ff >= SW'(2) && (4'(sect_ff) + 4'd1) < ns_eff) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_EREAD;
            end
         end
         ST_EREAD: state_in = ST_EACC;
         ST_EACC: begin
            if (eidx_ff == EW'(0) || eidx_ff == EW'(2)) begin
               state_in = ST_READ;
            end else if (eidx_ff == EW'(1)) begin
               state_in = ST_EREAD;
            end else if ((6'(band_ff) + 6'd1) < nb_eff) begin
               state_in = ST_READ;
            end else if (count_ff + FRAME_BITS'(1) >= fl_eff) begin
               state_in = ST_EMIT_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_READ: state_in = ST_EMIT_LOAD;
         ST_EMIT_LOAD: begin
            if (load_ok) begin
               state_in = is_last ? ST_IDLE : ST_EMIT_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      slot_in      = slot_ff;
      band_in      = band_ff;
      sect_in      = sect_ff;
      eidx_in      = eidx_ff;
      count_in     = count_ff;
      x_in         = x_ff;
      xcur_in      = xcur_ff;
      yacc_in      = yacc_ff;
      sq_in        = sq_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.action == ACTION_SAMPLE) begin
               x_in    = req_data.sample;
               xcur_in = req_data.sample;
               slot_in = '0;
            end
         end
         ST_WRITE: begin
            if (slot_ff < SW'(2)) begin
               eidx_in = EW'(slot_ff);
               yacc_in = bq_y;
            end else if ((4'(sect_ff) + 4'd1) < ns_eff) begin
               sect_in = sect_ff + CW'(1);
               slot_in = slot_ff + SW'(1);
               xcur_in = bq_y;
            end else begin
               eidx_in = EW'(3 + int'(band_ff));
               yacc_in = bq_y;
            end
         end
         ST_EREAD: begin
            sq_in = yacc_ff * yacc_ff;
         end
         ST_EACC: begin
            if (eidx_ff == EW'(0)) begin
               slot_in = SW'(1);
               xcur_in = x_ff;
            end else if (eidx_ff == EW'(1)) begin
               eidx_in = EW'(2);
               yacc_in = x_ff;
            end else if (eidx_ff == EW'(2)) begin
               slot_in = SW'(2);
               band_in = '0;
               sect_in = '0;
               xcur_in = x_ff;
            end else if ((6'(band_ff) + 6'd1) < nb_eff) begin
               band_in = band_ff + BW'(1);
               sect_in = '0;
               slot_in = SW'(2 + (int'(band_ff) + 1) * SECTIONS);
               xcur_in = x_ff;
            end else if (count_ff + FRAME_BITS'(1) >= fl_eff) begin
               count_in = '0;
               eidx_in  = '0;
            end else begin
               count_in = count_ff + FRAME_BITS'(1);
            end
         end
         ST_EMIT_LOAD: begin
            if (load_ok) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.energy = eng_cur;
               rsp_data_in.last   = is_last;
               if (eidx_ff < EW'(3)) begin
                  rsp_data_in.kind = 2'(eidx_ff);
                  rsp_data_in.band = 5'd0;
               end else begin
                  rsp_data_in.kind = KIND_BAND;
                  rsp_data_in.band = 5'(eidx_ff - EW'(3));
               end
               if (!is_last) begin
                  eidx_in = eidx_ff + EW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bands_ff     <= 5'd25;
         sects_ff     <= 3'd4;
         flen_ff      <= FRAME_BITS'(48000);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dvalid_ff    <= '0;
         evalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BANDS:    bands_ff <= csr_data[4:0];
               REG_SECTIONS: sects_ff <= csr_data[2:0];
               REG_FRAME:    flen_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         if (delay_we) begin
            dvalid_ff[slot_ff] <= 1'b1;
         end
         if (emit_done) begin
            evalid_ff <= '0;
         end else if (eng_we) begin
            evalid_ff[eidx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      band_ff     <= band_in;
      sect_ff     <= sect_in;
      eidx_ff     <= eidx_in;
      x_ff        <= x_in;
      xcur_ff     <= xcur_in;
      yacc_ff     <= yacc_in;
      sq_ff       <= sq_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[cw_slot][req_data.coef_select] <= req_data.coef_value;
      end
      coef_rd_ff <= coef_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (delay_we) begin
         delay_mem[slot_ff] <= {n1, n2};
      end
      delay_rd_ff <= delay_mem[slot_ff];
      dval_rd_ff  <= dvalid_ff[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (eng_we) begin
         eng_mem[eidx_ff] <= eng_wdata;
      end
      eng_rd_ff  <= eng_mem[eidx_ff];
      eval_rd_ff <= evalid_ff[eidx_ff];
   end

endmodule
`default_nettype wire

### design/fbfe_biquad.sv
// Shared datapath for one transposed direct form II biquad section.
// Multiplies, rounds and saturates over three steps set by the sequencer control struct.
// Depends on fbfe_pkg.
`default_nettype none
module fbfe_biquad (
   input  wire logic                 clock,
   input  wire fbfe_pkg::bq_ctrl_type ctrl,
   input  wire fbfe_pkg::sample_type x,
   input  wire fbfe_pkg::coef_row_type coef,
   input  wire fbfe_pkg::delay_type  z1,
   input  wire fbfe_pkg::delay_type  z2,
   output fbfe_pkg::sample_type      y,
   output fbfe_pkg::delay_type       n1,
   output fbfe_pkg::delay_type       n2
);
   import fbfe_pkg::*;

   localparam int AW = STATE_BITS + 4;
   localparam int NW = STATE_BITS + 5;
   localparam logic signed [AW-1:0] ROUND_HALF = AW'(64'sd1 <<< (OUT_SHIFT - 1));
   localparam logic signed [AW-1:0] Y_MAX = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [AW-1:0] Y_MIN = -Y_MAX - AW'(1);
   localparam logic signed [NW-1:0] Z_MAX = NW'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
   localparam logic signed [NW-1:0] Z_MIN = -Z_MAX - NW'(1);

   logic signed [PROD_BITS-1:0] p0_ff, p1_ff, p2_ff, q1_ff, q2_ff;
   sample_type                  y_ff;
   logic signed [AW-1:0]        acc, shifted;
   sample_type                  y_in;
   logic signed [NW-1:0]        s1, s2;

   always_comb begin
      acc     = AW'(p0_ff >>> PROD_SHIFT) + AW'(z1) + ROUND_HALF;
      shifted = acc >>> OUT_SHIFT;
      if (shifted > Y_MAX) begin
         y_in = SAMPLE_BITS'(Y_MAX);
      end else if (shifted < Y_MIN) begin
         y_in = SAMPLE_BITS'(Y_MIN);
      end else begin
         y_in = SAMPLE_BITS'(shifted);
      end
   end

   always_comb begin
      s1 = NW'(p1_ff >>> PROD_SHIFT) - NW'(q1_ff >>> PROD_SHIFT) + NW'(z2);
      s2 = NW'(p2_ff >>> PROD_SHIFT) - NW'(q2_ff >>> PROD_SHIFT);
      if (s1 > Z_MAX) begin
         n1 = STATE_BITS'(Z_MAX);
      end else if (s1 < Z_MIN) begin
         n1 = STATE_BITS'(Z_MIN);
      end else begin
         n1 = STATE_BITS'(s1);
      end
      if (s2 > Z_MAX) begin
         n2 = STATE_BITS'(Z_MAX);
      end else if (s2 < Z_MIN) begin
         n2 = STATE_BITS'(Z_MIN);
      end else begin
         n2 = STATE_BITS'(s2);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_x) begin
         p0_ff <= coef[SEL_B0] * x;
         p1_ff <= coef[SEL_B1] * x;
         p2_ff <= coef[SEL_B2] * x;
      end
      if (ctrl.round) begin
         y_ff <= y_in;
      end
      if (ctrl.mul_y) begin
         q1_ff <= coef[SEL_A1] * y_ff;
         q2_ff <= coef[SEL_A2] * y_ff;
      end
   end

   assign y = y_ff;

endmodule
`default_nettype wire
